>>> design/circular_deque_with_search_macros.svh
// Assertion macros used by the deque datapath.
`ifndef CIRCULAR_DEQUE_WITH_SEARCH_MACROS_SVH
`define CIRCULAR_DEQUE_WITH_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define CDS_ASSERT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CDS_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error(msg);

`else

`define CDS_ASSERT(label, clk_sig, rstn_sig, ante, cons, msg)
`define CDS_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg)

`endif

`endif

>>> design/cds_pkg.sv
// Types and constants for the circular deque with search.
package cds_pkg;

    localparam int ELEM_PORT_W  = 32;
    localparam int POS_PORT_W   = 10;
    localparam int FOUND_PORT_W = 10;
    localparam int COUNT_PORT_W = 11;
    localparam int WIDE_W       = 64;   // widest element storage supported

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ_AT    = 3'd4,
        CMD_WRITE_AT   = 3'd5,
        CMD_FIND       = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_RANGE     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RESP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_cmd;
        logic    push_back;
        logic    push_front;
        logic    pop_back;
        logic    pop_front;
        logic    rd;
        logic    wr;
        logic    clr;
        logic    scan_start;
        logic    scan_read;
        logic    scan_next;
        logic    set_found;
        logic    set_status;
        status_t status_code;
        logic    cap_data;
        logic    load_rsp;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
        logic range_bad;
        logic match;
        logic scan_last;
        logic rsp_free;
    } ctrl_sts_t;

endpackage

>>> design/cds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/cds_ctrl.sv
// Command sequencer for the circular deque.
module cds_ctrl
    import cds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load_cmd = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                unique case (sts.cmd)
                    CMD_PUSH_BACK:
                    begin
                        if (sts.full)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = STAT_FULL;
                        end
                        else
                        begin
                            ctl.push_back = 1'b1;
                        end
                    end
                    CMD_PUSH_FRONT:
                    begin
                        if (sts.full)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = STAT_FULL;
                        end
                        else
                        begin
                            ctl.push_front = 1'b1;
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (sts.empty)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = STAT_EMPTY;
                        end
                        else
                        begin
                            ctl.pop_back = 1'b1;
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (sts.empty)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = STAT_EMPTY;
                        end
                        else
                        begin
                            ctl.pop_front = 1'b1;
                        end
                    end
                    CMD_READ_AT:
                    begin
                        if (sts.range_bad)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = STAT_RANGE;
                        end
                        else
                        begin
                            ctl.rd     = 1'b1;
                            state_next = S_RD_WAIT;
                        end
                    end
                    CMD_WRITE_AT:
                    begin
                        if (sts.range_bad)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = STAT_RANGE;
                        end
                        else
                        begin
                            ctl.wr = 1'b1;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (sts.empty)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = STAT_NOT_FOUND;
                        end
                        else
                        begin
                            ctl.scan_start = 1'b1;
                            state_next     = S_SCAN_RD;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        ctl.clr = 1'b1;
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                ctl.cap_data = 1'b1;
                state_next   = S_RESP;
            end
            S_SCAN_RD:
            begin
                ctl.scan_read = 1'b1;
                state_next    = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                priority if (sts.match)
                begin
                    ctl.set_found = 1'b1;
                    state_next    = S_RESP;
                end
                else if (sts.scan_last)
                begin
                    ctl.set_status  = 1'b1;
                    ctl.status_code = STAT_NOT_FOUND;
                    state_next      = S_RESP;
                end
                else
                begin
                    ctl.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_RESP:
            begin
                if (sts.rsp_free)
                begin
                    ctl.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cmd_stall = (state_reg != S_IDLE);

endmodule

>>> design/cds_dp.sv
// Deque datapath: pointers, slot arithmetic, storage RAM and result registers.
`include "circular_deque_with_search_macros.svh"

module cds_dp
    import cds_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [2:0]              command,
    input  logic [ELEM_PORT_W-1:0]  element,
    input  logic [POS_PORT_W-1:0]   position,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic [ELEM_PORT_W-1:0]  data,
    output logic [FOUND_PORT_W-1:0] found_index,
    output logic [2:0]              status,
    output logic [COUNT_PORT_W-1:0] count,
    input  ctrl_cmd_t               ctl,
    output ctrl_sts_t               sts
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_PORT_W) ? CW : POS_PORT_W;
    localparam logic [AW:0]   CAP_SUM   = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] OCC_FULL  = CW'(CAPACITY);

    // pointers
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;

    // latched transaction
    cmd_t                  cmd_reg;
    logic [DATA_WIDTH-1:0] elem_reg;
    logic [POS_PORT_W-1:0] pos_reg;
    logic [AW-1:0]         idx_reg;

    // results
    logic [ELEM_PORT_W-1:0]  data_reg;
    logic [AW-1:0]           found_reg;
    status_t                 status_reg;
    logic                    rsp_valid_reg;
    logic [ELEM_PORT_W-1:0]  rsp_data_reg;
    logic [FOUND_PORT_W-1:0] rsp_found_reg;
    status_t                 rsp_status_reg;
    logic [COUNT_PORT_W-1:0] count_reg;

    logic [WIDE_W-1:0]     elem_wide;
    logic [WIDE_W-1:0]     rd_wide;
    logic [31:0]           found_wide;
    logic [31:0]           occ_wide;
    logic [PW-1:0]         pos_ext;
    logic [AW-1:0]         offset;
    logic [AW:0]           slot_sum;
    logic [AW-1:0]         slot;
    logic [AW-1:0]         head_minus;
    logic                  full;
    logic                  empty;
    logic                  rsp_free;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    assign elem_wide  = WIDE_W'(element);
    assign rd_wide    = WIDE_W'(mem_rdata);
    assign pos_ext    = PW'(pos_reg);
    assign full       = (occ_reg == OCC_FULL);
    assign empty      = (occ_reg == '0);
    assign head_minus = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    // logical offset from head for this cycle's access
    always_comb
    begin
        priority if (ctl.push_back)
        begin
            offset = occ_reg[AW-1:0];
        end
        else if (ctl.pop_front)
        begin
            offset = AW'(1);
        end
        else if (ctl.scan_read)
        begin
            offset = idx_reg;
        end
        else
        begin
            offset = pos_ext[AW-1:0];
        end
    end

    // both operands below CAPACITY, so one subtract wraps the sum
    assign slot_sum = (AW + 1)'(head_reg) + (AW + 1)'(offset);
    assign slot     = (slot_sum >= CAP_SUM) ? AW'(slot_sum - CAP_SUM) : slot_sum[AW-1:0];

    assign mem_we    = ctl.push_back || ctl.push_front || ctl.wr;
    assign mem_re    = ctl.rd || ctl.scan_read;
    assign mem_waddr = ctl.push_front ? head_minus : slot;

    cds_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (elem_reg),
        .re    (mem_re),
        .raddr (slot),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        head_next = head_reg;
        occ_next  = occ_reg;
        priority if (ctl.clr)
        begin
            head_next = '0;
            occ_next  = '0;
        end
        else if (ctl.push_back)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (ctl.push_front)
        begin
            head_next = head_minus;
            occ_next  = occ_reg + 1'b1;
        end
        else if (ctl.pop_back)
        begin
            occ_next = occ_reg - 1'b1;
        end
        else if (ctl.pop_front)
        begin
            head_next = slot;
            occ_next  = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
            if (ctl.load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign found_wide = 32'(found_reg);
    assign occ_wide   = 32'(occ_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load_cmd)
        begin
            cmd_reg    <= cmd_t'(command);
            elem_reg   <= elem_wide[DATA_WIDTH-1:0];
            pos_reg    <= position;
            data_reg   <= '0;
            found_reg  <= '0;
            status_reg <= STAT_OK;
        end
        else
        begin
            if (ctl.set_status)
            begin
                status_reg <= ctl.status_code;
            end
            if (ctl.cap_data)
            begin
                data_reg <= rd_wide[ELEM_PORT_W-1:0];
            end
            if (ctl.set_found)
            begin
                found_reg <= idx_reg;
            end
        end
        if (ctl.scan_start)
        begin
            idx_reg <= '0;
        end
        else if (ctl.scan_next)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (ctl.load_rsp)
        begin
            rsp_data_reg   <= data_reg;
            rsp_found_reg  <= found_wide[FOUND_PORT_W-1:0];
            rsp_status_reg <= status_reg;
            count_reg      <= occ_wide[COUNT_PORT_W-1:0];
        end
    end

    always_comb
    begin
        sts.cmd       = cmd_reg;
        sts.full      = full;
        sts.empty     = empty;
        sts.range_bad = (pos_ext >= PW'(occ_reg));
        sts.match     = (mem_rdata == elem_reg);
        sts.scan_last = ((CW'(idx_reg) + 1'b1) == occ_reg);
        sts.rsp_free  = rsp_free;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign data        = rsp_data_reg;
    assign found_index = rsp_found_reg;
    assign status      = rsp_status_reg;
    assign count       = count_reg;

    `CDS_ASSERT(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= OCC_FULL, "occupancy above capacity")
    `CDS_ASSERT(a_head_bound, clk, rst_n, 1'b1, head_reg <= LAST_SLOT, "head beyond last slot")
    `CDS_ASSERT(a_push_room, clk, rst_n, ctl.push_back || ctl.push_front, !full, "push while full")
    `CDS_ASSERT(a_mem_port, clk, rst_n, mem_we, !mem_re, "storage read and write in one cycle")
    `CDS_ASSERT_NEXT(a_rsp_count, clk, rst_n, ctl.load_rsp, rsp_valid_reg && (count_reg == occ_wide[COUNT_PORT_W-1:0]), "result count differs from occupancy")

endmodule

>>> design/circular_deque_with_search.sv
// Top level of the circular deque with search.
// Double-ended circular buffer of CAPACITY elements of DATA_WIDTH bits, one
// result transaction per command transaction. Commands run one at a time
// through one storage RAM that is never read and written in the same cycle:
// push, pop, write_at, clear and any rejected command pass through accept,
// execute and respond; read_at in range also passes through a read-wait
// state for the registered RAM read; find reads and compares one element
// after another, stopping at the first match or after the last element (on
// an empty deque it examines none). A result waits in an output register,
// and the next command is taken while it waits; the respond state of that
// next command holds for as long as the waiting result is still stalled.
// Storage has no reset and no clearing pass; only occupied slots are ever
// read. Clear resets head and count only.
module circular_deque_with_search
    import cds_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_stall,
    input  logic [2:0]              command,
    input  logic [ELEM_PORT_W-1:0]  element,
    input  logic [POS_PORT_W-1:0]   position,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic [ELEM_PORT_W-1:0]  data,
    output logic [FOUND_PORT_W-1:0] found_index,
    output logic [2:0]              status,
    output logic [COUNT_PORT_W-1:0] count
);

    ctrl_cmd_t ctl;
    ctrl_sts_t sts;

    cds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    cds_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .element     (element),
        .position    (position),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .data        (data),
        .found_index (found_index),
        .status      (status),
        .count       (count),
        .ctl         (ctl),
        .sts         (sts)
    );

endmodule
